>>> hw/rtl/accel_tilt_angles_assert.svh
// Assertion macros used by the checker file.
`ifndef ACCEL_TILT_ANGLES_ASSERT_SVH
`define ACCEL_TILT_ANGLES_ASSERT_SVH

// Same-cycle implication.
`define ATA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ATA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/ata_pkg.sv
// Package: constants, types and functions of the tilt angle block.
package ata_pkg;

   localparam int CordicStagesDefault = 16;
   localparam int AngleFracDefault    = 8;
   localparam int TableLen            = 24;
   localparam int SqrtSteps           = 24;
   localparam int SqrtW               = 48;
   localparam int DenW                = 24;
   localparam int NumW                = 25;
   localparam int CordW               = 28;
   localparam int AccW                = 29;

   typedef struct packed {
      logic zero_den;
      logic num_zero;
      logic num_neg;
   } flags_type;

   typedef struct packed {
      logic signed [NumW-1:0] nn;
      flags_type              flags;
   } side_type;

   // atan(2^-i) in 2^-20 degree units
   function automatic logic signed [AccW-1:0] rot_angle(input int idx);
      logic signed [AccW-1:0] v;
      begin
         case (idx)
            0:  v = 29'sd47185920;
            1:  v = 29'sd27855475;
            2:  v = 29'sd14718068;
            3:  v = 29'sd7471121;
            4:  v = 29'sd3750058;
            5:  v = 29'sd1876857;
            6:  v = 29'sd938658;
            7:  v = 29'sd469357;
            8:  v = 29'sd234682;
            9:  v = 29'sd117342;
            10: v = 29'sd58671;
            11: v = 29'sd29335;
            12: v = 29'sd14668;
            13: v = 29'sd7334;
            14: v = 29'sd3667;
            15: v = 29'sd1833;
            16: v = 29'sd917;
            17: v = 29'sd458;
            18: v = 29'sd229;
            19: v = 29'sd115;
            20: v = 29'sd57;
            21: v = 29'sd29;
            22: v = 29'sd14;
            23: v = 29'sd7;
            default: v = '0;
         endcase
         return v;
      end
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
      logic signed [15:0] r;
      begin
         if (v > 32'sd32767) r = 16'sh7FFF;
         else if (v < -32'sd32768) r = 16'sh8000;
         else r = v[15:0];
         return r;
      end
   endfunction

endpackage

>>> hw/rtl/ata_sqrt_cell.sv
// One digit step of the pipelined integer square root.
module ata_sqrt_cell import ata_pkg::*; #(
   parameter int K = 0
) (
   input  logic             clock,
   input  logic             en,
   input  logic [SqrtW-1:0] n_in_d,
   input  logic [SqrtW-1:0] r_in_d,
   input  side_type         side_d,
   output logic [SqrtW-1:0] n_q,
   output logic [SqrtW-1:0] r_q,
   output side_type         side_q
);
   localparam logic [SqrtW-1:0] Bit = SqrtW'(1) << (2*K);

   logic [SqrtW-1:0] trial;
   logic [SqrtW-1:0] n_ff, n_in, r_ff, r_in;
   side_type         side_ff;

   always_comb begin
      trial = r_in_d + Bit;
      if (n_in_d >= trial) begin
         n_in = n_in_d - trial;
         r_in = (r_in_d >> 1) + Bit;
      end else begin
         n_in = n_in_d;
         r_in = r_in_d >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff    <= n_in;
         r_ff    <= r_in;
         side_ff <= side_d;
      end
   end

   assign n_q    = n_ff;
   assign r_q    = r_ff;
   assign side_q = side_ff;
endmodule

>>> hw/rtl/ata_cordic_cell.sv
// One CORDIC vectoring rotation with its angle accumulation.
module ata_cordic_cell import ata_pkg::*; #(
   parameter int IDX = 0
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic signed [CordW-1:0] a_d,
   input  logic signed [CordW-1:0] b_d,
   input  logic signed [AccW-1:0]  acc_d,
   input  flags_type               flags_d,
   output logic signed [CordW-1:0] a_q,
   output logic signed [CordW-1:0] b_q,
   output logic signed [AccW-1:0]  acc_q,
   output flags_type               flags_q
);
   localparam logic signed [AccW-1:0] Rot = rot_angle(IDX);

   logic signed [CordW-1:0] a_ff, a_in, b_ff, b_in;
   logic signed [AccW-1:0]  acc_ff, acc_in;
   flags_type               flags_ff;

   always_comb begin
      if (!b_d[CordW-1]) begin
         a_in   = a_d + (b_d >>> IDX);
         b_in   = b_d - (a_d >>> IDX);
         acc_in = acc_d + Rot;
      end else begin
         a_in   = a_d - (b_d >>> IDX);
         b_in   = b_d + (a_d >>> IDX);
         acc_in = acc_d - Rot;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff     <= a_in;
         b_ff     <= b_in;
         acc_ff   <= acc_in;
         flags_ff <= flags_d;
      end
   end

   assign a_q     = a_ff;
   assign b_q     = b_ff;
   assign acc_q   = acc_ff;
   assign flags_q = flags_ff;
endmodule

>>> hw/rtl/ata_lane.sv
// One tilt angle: squares, root chain, CORDIC chain and output rounding.
module ata_lane import ata_pkg::*; #(
   parameter int STAGES = CordicStagesDefault,
   parameter int FRAC   = AngleFracDefault
) (
   input  logic               clock,
   input  logic               en,
   input  logic signed [16:0] num,
   input  logic signed [15:0] a,
   input  logic signed [15:0] b,
   output logic signed [15:0] angle,
   output logic               degen
);
   logic signed [31:0] prod_a, prod_b;
   logic [31:0]        sqa_ff, sqb_ff;
   side_type           side0_ff;
   side_type           side1_ff;
   logic [SqrtW-1:0]   n1_ff;

   assign prod_a = a * a;
   assign prod_b = b * b;

   always_ff @(posedge clock) begin
      if (en) begin
         sqa_ff                  <= unsigned'(prod_a);
         sqb_ff                  <= unsigned'(prod_b);
         side0_ff.nn             <= NumW'({num, 8'b0});
         side0_ff.flags.zero_den <= (a == '0) && (b == '0);
         side0_ff.flags.num_zero <= (num == '0);
         side0_ff.flags.num_neg  <= num[16];
         n1_ff                   <= {sqa_ff + sqb_ff, 16'b0};
         side1_ff                <= side0_ff;
      end
   end

   // square root chain, one result bit per cell
   logic [SqrtW-1:0] sq_n [0:SqrtSteps];
   logic [SqrtW-1:0] sq_r [0:SqrtSteps];
   side_type         sq_s [0:SqrtSteps];

   assign sq_n[0] = n1_ff;
   assign sq_r[0] = '0;
   assign sq_s[0] = side1_ff;

   for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
      ata_sqrt_cell #(.K(SqrtSteps-1-k)) u_cell (
         .clock  (clock),
         .en     (en),
         .n_in_d (sq_n[k]),
         .r_in_d (sq_r[k]),
         .side_d (sq_s[k]),
         .n_q    (sq_n[k+1]),
         .r_q    (sq_r[k+1]),
         .side_q (sq_s[k+1])
      );
   end

   // CORDIC chain
   logic signed [CordW-1:0] c_a   [0:STAGES];
   logic signed [CordW-1:0] c_b   [0:STAGES];
   logic signed [AccW-1:0]  c_acc [0:STAGES];
   flags_type               c_f   [0:STAGES];

   assign c_a[0]   = signed'(CordW'(sq_r[SqrtSteps][DenW-1:0]));
   assign c_b[0]   = CordW'(sq_s[SqrtSteps].nn);
   assign c_acc[0] = '0;
   assign c_f[0]   = sq_s[SqrtSteps].flags;

   for (genvar j = 0; j < STAGES; j++) begin : g_cordic
      ata_cordic_cell #(.IDX(j)) u_cell (
         .clock   (clock),
         .en      (en),
         .a_d     (c_a[j]),
         .b_d     (c_b[j]),
         .acc_d   (c_acc[j]),
         .flags_d (c_f[j]),
         .a_q     (c_a[j+1]),
         .b_q     (c_b[j+1]),
         .acc_q   (c_acc[j+1]),
         .flags_q (c_f[j+1])
      );
   end

   // round half up, then saturate; bypass on zero denominator
   localparam logic signed [31:0] Half  = 32'sd1 <<< (19 - FRAC);
   localparam logic signed [31:0] Right = 32'sd90 <<< FRAC;

   logic signed [31:0] acc_w, rounded;
   logic signed [15:0] angle_ff, angle_in;
   logic               degen_ff, degen_in;
   flags_type          fl;

   always_comb begin
      fl      = c_f[STAGES];
      acc_w   = 32'(c_acc[STAGES]);
      rounded = (acc_w + Half) >>> (20 - FRAC);
      degen_in = 1'b0;
      if (fl.zero_den) begin
         if (fl.num_zero) begin
            angle_in = '0;
            degen_in = 1'b1;
         end else if (fl.num_neg) begin
            angle_in = sat16(-Right);
         end else begin
            angle_in = sat16(Right);
         end
      end else begin
         angle_in = sat16(rounded);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         angle_ff <= angle_in;
         degen_ff <= degen_in;
      end
   end

   assign angle = angle_ff;
   assign degen = degen_ff;
endmodule

>>> hw/rtl/accel_tilt_angles.sv
// Top level: accelerometer tilt angles, two pipelined root plus CORDIC lanes.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_ready | req_accel_x, req_accel_y, req_accel_z
//   rsp     | out       | rsp_valid/rsp_ready | rsp_roll_angle, rsp_pitch_angle, rsp_degenerate
//
// One request per cycle is taken while the output is not stalled; each result passes
// the square, sum, 24 root cells, min(CORDIC_STAGES, 24) CORDIC cells and output register,
// so its delay is set by the root and CORDIC cell chains.
// Reset (synchronous, active high) clears only the valid bits of the pipe.
// When rsp_valid is high and rsp_ready low the whole pipe holds and req_ready drops.
module accel_tilt_angles import ata_pkg::*; #(
   parameter int CORDIC_STAGES   = CordicStagesDefault,
   parameter int ANGLE_FRAC_BITS = AngleFracDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_roll_angle,
   output logic signed [15:0] rsp_pitch_angle,
   output logic [1:0]         rsp_degenerate
);
   // stage count is capped at the length of the rotation table
   localparam int Used = (CORDIC_STAGES > TableLen) ? TableLen : CORDIC_STAGES;
   localparam int Lat  = 3 + SqrtSteps + Used;

   logic            en;
   logic [Lat-1:0]  vld_ff, vld_in;
   logic            d_roll, d_pitch;
   logic signed [16:0] neg_x;

   // pipe advances unless a finished result is held by the receiver
   assign en        = !vld_ff[Lat-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[Lat-1];

   assign vld_in = {vld_ff[Lat-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // pitch numerator is -x, one bit wider so -(-32768) fits
   assign neg_x = -(17'(req_accel_x));

   ata_lane #(.STAGES(Used), .FRAC(ANGLE_FRAC_BITS)) u_roll (
      .clock (clock),
      .en    (en),
      .num   (17'(req_accel_y)),
      .a     (req_accel_x),
      .b     (req_accel_z),
      .angle (rsp_roll_angle),
      .degen (d_roll)
   );

   ata_lane #(.STAGES(Used), .FRAC(ANGLE_FRAC_BITS)) u_pitch (
      .clock (clock),
      .en    (en),
      .num   (neg_x),
      .a     (req_accel_y),
      .b     (req_accel_z),
      .angle (rsp_pitch_angle),
      .degen (d_pitch)
   );

   assign rsp_degenerate = {d_pitch, d_roll};
endmodule

>>> hw/rtl/ata_checker.sv
// Port-level checker for the tilt angle block, with its bind.
`include "accel_tilt_angles_assert.svh"

module ata_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic signed [15:0] rsp_roll_angle,
   input logic signed [15:0] rsp_pitch_angle,
   input logic [1:0]        rsp_degenerate
);
   `ATA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_roll_angle) && $stable(rsp_pitch_angle) && $stable(rsp_degenerate), "held response changed")
   `ATA_ASSERT_IMPLY(a_stall_blocks, clock, reset, rsp_valid && !rsp_ready, !req_ready, "request taken while output stalled")
   `ATA_ASSERT_IMPLY(a_roll_degen, clock, reset, rsp_valid && rsp_degenerate[0], rsp_roll_angle == 16'sd0, "degenerate roll not zero")
   `ATA_ASSERT_IMPLY(a_pitch_degen, clock, reset, rsp_valid && rsp_degenerate[1], rsp_pitch_angle == 16'sd0, "degenerate pitch not zero")
   `ATA_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "response valid after reset")
endmodule

bind accel_tilt_angles ata_checker u_ata_checker (.*);
